// ===== hw/rtl/mecanum_wheel_mixer_defines.svh =====
// assertion macros for the mecanum wheel mixer
// included by the rtl files that carry concurrent checks; no other dependencies
`ifndef MECANUM_WHEEL_MIXER_DEFINES_SVH
`define MECANUM_WHEEL_MIXER_DEFINES_SVH
`ifndef ASSERT_OFF
`define CHECK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHECK_IMPLY(label, clk, rst, ante, cons, msg)
`define CHECK_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/mwm_pkg.sv =====
// shared widths, register codes, reset values and stage payload types
// for the mecanum wheel mixer; no dependencies
package mwm_pkg;

   localparam int WHEELS  = 4;
   localparam int IN_W    = 16;
   localparam int OUT_W   = 16;
   localparam int Q_FRAC  = 12;
   localparam int PRODQ_W = 2 * IN_W;
   // mixed wheel value, signed; magnitude stays below 2^19
   localparam int MIX_W   = 20;
   localparam int MAG_W   = MIX_W - 1;
   localparam int MAXS_W  = 15;
   localparam int PROD_W  = MAG_W + MAXS_W;
   localparam int QUOT_W  = MAXS_W;
   localparam int QIDX_W  = $clog2(QUOT_W);
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic signed [PRODQ_W-1:0] Q_ROUND = PRODQ_W'((1 << Q_FRAC) - 1);
   localparam logic signed [MIX_W-1:0]   SAT_HI  = MIX_W'(32767);
   localparam logic signed [MIX_W-1:0]   SAT_LO  = -MIX_W'(32768);

   localparam logic signed [IN_W-1:0] FRONT_COEF_RST = -IN_W'(737);
   localparam logic signed [IN_W-1:0] REAR_COEF_RST  = -IN_W'(901);
   localparam logic [MAXS_W-1:0]      MAX_SPEED_RST  = MAXS_W'(16384);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRONT_COEF,
      CSR_REAR_COEF,
      CSR_MAX_SPEED
   } csr_index_type;

   // after mixing and the magnitude search
   typedef struct packed {
      logic [WHEELS-1:0][MIX_W-1:0] wheel;
      logic [WHEELS-1:0][MAG_W-1:0] mag;
      logic [MAG_W-1:0]             largest;
      logic                         raw;
   } mix_type;

   // one step of the long division, all four wheels side by side
   typedef struct packed {
      logic [WHEELS-1:0][PROD_W-1:0] rem;
      logic [WHEELS-1:0][QUOT_W-1:0] quot;
      logic [WHEELS-1:0]             neg;
      logic [WHEELS-1:0][OUT_W-1:0]  sat;
      logic [MAG_W-1:0]              divisor;
      logic                          scale;
   } div_type;

endpackage

// ===== hw/rtl/mecanum_wheel_mixer.sv =====
// Mecanum wheel mixer with desaturation, top level.
// Request channel (req_): forward, side and turn commands in Q3.12 plus a raw
// mode bit; a transfer happens on a clock edge with req_valid high and
// req_stall low. Response channel (rsp_): the four wheel values, same rule.
// The csr_ port writes the front and rear rotation coefficients and the
// maximum wheel speed on any edge with csr_wen high; write it only while idle.
// The request passes through 20 register stages, the last of which is the
// output register that drives rsp_valid.
// Stages: three mixing, one scaling setup with the dividend multipliers,
// fifteen divider stages (one quotient bit each) and the output register.
// One command per cycle unless the receiver stalls; each stage has a valid bit.
// When the receiver stalls, bubbles close up first and req_stall rises only
// once every stage holds a command; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and restores the register defaults
// (front -737, rear -901, maximum speed 4.0).
// Depends on mwm_pkg, mwm_mix, mwm_scale and mwm_divider.
module mecanum_wheel_mixer import mwm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [IN_W-1:0] req_forward_speed,
   input  logic signed [IN_W-1:0] req_side_speed,
   input  logic signed [IN_W-1:0] req_turn_rate,
   input  logic                   req_raw_mode,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [OUT_W-1:0] rsp_wheel_0,
   output logic signed [OUT_W-1:0] rsp_wheel_1,
   output logic signed [OUT_W-1:0] rsp_wheel_2,
   output logic signed [OUT_W-1:0] rsp_wheel_3,
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DAT_W-1:0]   csr_wdata
);

   logic signed [IN_W-1:0] front_coef_ff, rear_coef_ff;
   logic [MAXS_W-1:0]      max_speed_ff;

   logic    mix_in_ready, mix_valid, scale_ready, scale_valid, div_ready;
   mix_type mix_data;
   div_type scale_data;
   logic [WHEELS-1:0][OUT_W-1:0] wheels;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_coef_ff <= FRONT_COEF_RST;
         rear_coef_ff  <= REAR_COEF_RST;
         max_speed_ff  <= MAX_SPEED_RST;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRONT_COEF: front_coef_ff <= IN_W'(csr_wdata);
            CSR_REAR_COEF:  rear_coef_ff  <= IN_W'(csr_wdata);
            CSR_MAX_SPEED:  max_speed_ff  <= csr_wdata[MAXS_W-1:0];
            default: ;
         endcase
      end
   end

   mwm_mix u_mix (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (mix_in_ready),
      .forward_speed (req_forward_speed),
      .side_speed    (req_side_speed),
      .turn_rate     (req_turn_rate),
      .raw_mode      (req_raw_mode),
      .front_coef    (front_coef_ff),
      .rear_coef     (rear_coef_ff),
      .out_valid     (mix_valid),
      .out_ready     (scale_ready),
      .out_data      (mix_data)
   );

   mwm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_ready  (scale_ready),
      .in_data   (mix_data),
      .max_speed (max_speed_ff),
      .out_valid (scale_valid),
      .out_ready (div_ready),
      .out_data  (scale_data)
   );

   mwm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scale_valid),
      .in_ready  (div_ready),
      .in_data   (scale_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_wheel (wheels)
   );

   assign req_stall   = !mix_in_ready;
   assign rsp_wheel_0 = wheels[0];
   assign rsp_wheel_1 = wheels[1];
   assign rsp_wheel_2 = wheels[2];
   assign rsp_wheel_3 = wheels[3];

endmodule

// ===== hw/rtl/mwm_mix.sv =====
// front of the pipeline: rotation products, wheel mixing, magnitude search
// three register stages; uses mwm_pkg
module mwm_mix import mwm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [IN_W-1:0] forward_speed,
   input  logic signed [IN_W-1:0] side_speed,
   input  logic signed [IN_W-1:0] turn_rate,
   input  logic                   raw_mode,
   input  logic signed [IN_W-1:0] front_coef,
   input  logic signed [IN_W-1:0] rear_coef,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mix_type                out_data
);

   function automatic logic signed [MIX_W-1:0] q12_trunc(input logic signed [PRODQ_W-1:0] p);
      logic signed [PRODQ_W-1:0] adj;
      // bias negatives so the shift truncates toward zero
      adj = p[PRODQ_W-1] ? p + Q_ROUND : p;
      return MIX_W'(adj >>> Q_FRAC);
   endfunction

   logic                      s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                      s1_ready, s2_ready, s3_ready;
   logic signed [IN_W-1:0]    s1_vx_ff, s1_vy_ff;
   logic                      s1_raw_ff;
   logic signed [PRODQ_W-1:0] s1_fprod_ff, s1_rprod_ff, s1_fprod_in, s1_rprod_in;
   logic [WHEELS-1:0][MIX_W-1:0] s2_wheel_ff, s2_wheel_in;
   logic                      s2_raw_ff;
   mix_type                   s3_ff, s3_in;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_fprod_in = front_coef * turn_rate;
   assign s1_rprod_in = rear_coef * turn_rate;

   always_comb begin
      logic signed [MIX_W-1:0] vx, vy, front, rear;
      vx    = MIX_W'(s1_vx_ff);
      vy    = MIX_W'(s1_vy_ff);
      front = q12_trunc(s1_fprod_ff);
      rear  = q12_trunc(s1_rprod_ff);
      s2_wheel_in[0] = -vx - vy + front;
      s2_wheel_in[1] =  vx - vy + front;
      s2_wheel_in[2] =  vx + vy + rear;
      s2_wheel_in[3] = -vx + vy + rear;
   end

   always_comb begin
      logic [MAG_W-1:0] max01, max23;
      s3_in.wheel = s2_wheel_ff;
      s3_in.raw   = s2_raw_ff;
      for (int w = 0; w < WHEELS; w++) begin
         s3_in.mag[w] = s2_wheel_ff[w][MIX_W-1] ? MAG_W'(-$signed(s2_wheel_ff[w]))
                                                : MAG_W'(s2_wheel_ff[w]);
      end
      max01 = (s3_in.mag[0] > s3_in.mag[1]) ? s3_in.mag[0] : s3_in.mag[1];
      max23 = (s3_in.mag[2] > s3_in.mag[3]) ? s3_in.mag[2] : s3_in.mag[3];
      s3_in.largest = (max01 > max23) ? max01 : max23;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_vx_ff    <= forward_speed;
         s1_vy_ff    <= side_speed;
         s1_raw_ff   <= raw_mode;
         s1_fprod_ff <= s1_fprod_in;
         s1_rprod_ff <= s1_rprod_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_wheel_ff <= s2_wheel_in;
         s2_raw_ff   <= s1_raw_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

endmodule

// ===== hw/rtl/mwm_scale.sv =====
// scaling setup stage: desaturation decision, dividend product, saturated raw value
// one register stage; uses mwm_pkg
module mwm_scale import mwm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mix_type           in_data,
   input  logic [MAXS_W-1:0] max_speed,
   output logic              out_valid,
   input  logic              out_ready,
   output div_type           out_data
);

   function automatic logic [OUT_W-1:0] sat16(input logic signed [MIX_W-1:0] x);
      if (x > SAT_HI) return OUT_W'(SAT_HI);
      if (x < SAT_LO) return OUT_W'(SAT_LO);
      return OUT_W'(x);
   endfunction

   logic    valid_ff;
   div_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in.divisor = in_data.largest;
      data_in.scale   = !in_data.raw && (in_data.largest > MAG_W'(max_speed));
      for (int w = 0; w < WHEELS; w++) begin
         data_in.rem[w]  = PROD_W'(in_data.mag[w]) * PROD_W'(max_speed);
         data_in.quot[w] = '0;
         data_in.neg[w]  = in_data.wheel[w][MIX_W-1];
         data_in.sat[w]  = sat16($signed(in_data.wheel[w]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/mwm_divider.sv =====
// restoring divider, one quotient bit per stage for all four wheels, then
// the result select and output register; uses mwm_pkg and the assertion macros
`include "mecanum_wheel_mixer_defines.svh"
module mwm_divider import mwm_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  div_type                      in_data,
   output logic                         out_valid,
   input  logic                         out_stall,
   output logic [WHEELS-1:0][OUT_W-1:0] out_wheel
);

   function automatic div_type div_step(input div_type d, input logic [QIDX_W-1:0] k);
      div_type           r;
      logic [PROD_W-1:0] trial;
      r     = d;
      trial = PROD_W'(d.divisor) << k;
      for (int w = 0; w < WHEELS; w++) begin
         if (d.rem[w] >= trial) begin
            r.rem[w]     = d.rem[w] - trial;
            r.quot[w][k] = 1'b1;
         end
      end
      return r;
   endfunction

   div_type               stg_ff [QUOT_W];
   div_type               src_data [QUOT_W];
   logic [QUOT_W-1:0]     src_valid;
   logic [QUOT_W-1:0]     stg_valid_ff;
   logic [QUOT_W:0]       stg_ready;
   logic                  out_valid_ff;
   logic [WHEELS-1:0][OUT_W-1:0] out_wheel_ff, out_wheel_in;
   div_type               last;
   logic                  entry_ok, exit_ok;

   assign stg_ready[QUOT_W] = !out_valid_ff || !out_stall;
   assign in_ready = stg_ready[0];

   for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
      if (j == 0) begin : g_first
         assign src_data[j]  = in_data;
         assign src_valid[j] = in_valid;
      end else begin : g_next
         assign src_data[j]  = stg_ff[j-1];
         assign src_valid[j] = stg_valid_ff[j-1];
      end

      assign stg_ready[j] = !stg_valid_ff[j] || stg_ready[j+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_valid_ff[j] <= 1'b0;
         end else if (stg_ready[j]) begin
            stg_valid_ff[j] <= src_valid[j];
         end
      end

      // highest quotient bit first
      always_ff @(posedge clock) begin
         if (stg_ready[j] && src_valid[j]) begin
            stg_ff[j] <= div_step(src_data[j], QIDX_W'(QUOT_W - 1 - j));
         end
      end
   end

   assign last = stg_ff[QUOT_W-1];

   always_comb begin
      logic [OUT_W-1:0] mag;
      for (int w = 0; w < WHEELS; w++) begin
         mag = OUT_W'(last.quot[w]);
         out_wheel_in[w] = last.scale ? (last.neg[w] ? -mag : mag) : last.sat[w];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stg_ready[QUOT_W]) begin
         out_valid_ff <= stg_valid_ff[QUOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[QUOT_W] && stg_valid_ff[QUOT_W-1]) out_wheel_ff <= out_wheel_in;
   end

   assign out_valid = out_valid_ff;
   assign out_wheel = out_wheel_ff;

   // quotient must fit in QUOT_W bits on entry, and the remainder end below the divisor
   always_comb begin
      entry_ok = 1'b1;
      exit_ok  = 1'b1;
      for (int w = 0; w < WHEELS; w++) begin
         if (in_data.rem[w] >= {in_data.divisor, QUOT_W'(0)}) entry_ok = 1'b0;
         if (last.rem[w] >= PROD_W'(last.divisor)) exit_ok = 1'b0;
      end
   end

   `CHECK_IMPLY(a_entry_fits, clock, reset, in_valid && in_data.scale, entry_ok, "dividend overflows quotient width")
   `CHECK_IMPLY(a_exit_done, clock, reset, stg_valid_ff[QUOT_W-1] && last.scale, exit_ok, "division left remainder not below divisor")
   `CHECK_IMPLY(a_stall_full, clock, reset, !in_ready, (&stg_valid_ff) && out_valid_ff && out_stall, "divider refused input with a free slot")

endmodule
